### src/slot_id_free_list_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Slot ID free list allocator assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SLOT_ID_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define SLOT_ID_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SFLA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot id allocator assertion failed");
// Next-cycle implication.
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot id allocator assertion failed");
`else
`define SFLA_ASSERT(lbl, ante, cons)
`define SFLA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/sfla_pkg.sv
// ----------------------------------------------------------------------------
// Slot ID free list allocator package
// Sizes, request and status codes, and state type shared by the block.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int ID_W       = 10;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W      = (CNT_W > ID_W) ? CNT_W : ID_W;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_ISSUED = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } fsm_t;

endpackage

### src/sfla_ram.sv
// ----------------------------------------------------------------------------
// Slot ID free list allocator RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/slot_id_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// Slot ID free list allocator
// LIFO free-list allocator of slot identifiers for a fixed-size table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, mode, slot_id): mode 0 allocates an
//   identifier, mode 1 releases slot_id. Output channel (out_valid/out_ready,
//   granted_id, status) returns exactly one result per input transfer.
//   Released identifiers sit on a free stack held in a 1-port-write,
//   1-port-read RAM; allocation pops the stack, or hands out the high-water
//   mark when the stack is empty.
// Timing:
//   Release, fresh allocation and table-full answers land in the output
//   register in the cycle after the input transfer, one item per cycle
//   while the output register drains. An allocation that pops the free
//   stack first does the registered RAM read in S_POP; in_ready stays low.
// Reset:
//   Free count and high-water mark clear to zero; the stack RAM is not
//   cleared, since only entries below the free count are ever read.
// Stall:
//   A result held by a stalled receiver blocks in_ready only when the
//   output register cannot drain in the same cycle; a pending pop waits
//   with its RAM read data held.
// ----------------------------------------------------------------------------
`include "slot_id_free_list_allocator_top_assert.svh"

module slot_id_free_list_allocator_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [sfla_pkg::ID_W-1:0] slot_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [sfla_pkg::ID_W-1:0] granted_id,
  output logic [1:0]               status
);

  sfla_pkg::fsm_t state, state_next;

  // free stack depth and next never-issued identifier
  logic [sfla_pkg::CNT_W-1:0] free_count, free_count_next;
  logic [sfla_pkg::CNT_W-1:0] high_water, high_water_next;

  // stack RAM port
  logic                        wr_en, rd_en;
  logic [sfla_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [sfla_pkg::ID_W-1:0]   rd_data;

  // result to load into the output register
  logic                      load, out_free;
  logic [sfla_pkg::ID_W-1:0] res_id;
  sfla_pkg::status_t         res_st;

  // identifier and high-water mark at a common compare width
  logic [sfla_pkg::CMP_W-1:0] id_ext, hw_ext;

  assign id_ext  = sfla_pkg::CMP_W'(slot_id);
  assign hw_ext  = sfla_pkg::CMP_W'(high_water);
  assign wr_addr = sfla_pkg::ADDR_W'(free_count);
  assign rd_addr = sfla_pkg::ADDR_W'(free_count - sfla_pkg::CNT_W'(1));

  sfla_ram #(
    .WIDTH (sfla_pkg::ID_W),
    .DEPTH (sfla_pkg::SLOT_COUNT)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (slot_id),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sfla_pkg::S_IDLE;
      free_count <= '0;
      high_water <= '0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      high_water <= high_water_next;
    end
  end

  always_comb begin
    state_next      = state;
    free_count_next = free_count;
    high_water_next = high_water;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    load            = 1'b0;
    res_id          = '0;
    res_st          = sfla_pkg::ST_OK;
    // output register drains this cycle or is already empty
    out_free        = !out_valid || out_ready;
    in_ready        = (state == sfla_pkg::S_IDLE) && out_free;

    case (state)
      sfla_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          if (mode == sfla_pkg::MODE_ALLOC) begin
            if (free_count != '0) begin
              // pop: read the stack top, answer from S_POP
              rd_en           = 1'b1;
              free_count_next = free_count - sfla_pkg::CNT_W'(1);
              state_next      = sfla_pkg::S_POP;
            end else if (high_water < sfla_pkg::CNT_W'(sfla_pkg::SLOT_COUNT)) begin
              load            = 1'b1;
              res_id          = sfla_pkg::ID_W'(high_water);
              high_water_next = high_water + sfla_pkg::CNT_W'(1);
            end else begin
              load   = 1'b1;
              res_st = sfla_pkg::ST_FULL;
            end
          end else begin
            load = 1'b1;
            if (id_ext >= hw_ext) begin
              res_st = sfla_pkg::ST_NOT_ISSUED;
            end else if (free_count >= sfla_pkg::CNT_W'(sfla_pkg::SLOT_COUNT)) begin
              res_st = sfla_pkg::ST_OVERFLOW;
            end else begin
              // push
              wr_en           = 1'b1;
              free_count_next = free_count + sfla_pkg::CNT_W'(1);
            end
          end
        end
      end
      sfla_pkg::S_POP: begin
        if (out_free) begin
          load       = 1'b1;
          res_id     = rd_data;
          state_next = sfla_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sfla_pkg::S_IDLE;
      end
    endcase
  end

  // output register: valid under reset, payload without
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      granted_id <= res_id;
      status     <= res_st;
    end
  end

  `SFLA_ASSERT(a_count_bound, 1'b1, free_count <= sfla_pkg::CNT_W'(sfla_pkg::SLOT_COUNT))
  `SFLA_ASSERT(a_hw_bound, 1'b1, high_water <= sfla_pkg::CNT_W'(sfla_pkg::SLOT_COUNT))
  `SFLA_ASSERT(a_pop_blocks, state == sfla_pkg::S_POP, !in_ready && !wr_en)
  `SFLA_ASSERT_NEXT(a_pop_enters, rd_en, state == sfla_pkg::S_POP)
  `SFLA_ASSERT_NEXT(a_load_valid, load, out_valid)

endmodule

### verif/tb_slot_id_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// Slot ID free list allocator testbench
// Drives allocate and release requests through the valid/ready input channel.
// A local LIFO free-list model predicts each granted ID and status, and the
// result channel is compared against it field by field. The sequence covers
// directed corner cases, random traffic with idle cycles on both sides, a
// stretch without idle cycles, a long receiver stall, a full table, and a
// free stack overflow caused by repeated releases.
// ----------------------------------------------------------------------------
module tb_slot_id_free_list_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Abort when no transfer happens on either channel for this many cycles.
  localparam int STALL_LIMIT = 2000;
  // Receiver stall long enough to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [sfla_pkg::ID_W-1:0] granted;
    sfla_pkg::status_t         status;
  } grant_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid;
  logic                      in_ready;
  logic                      mode;
  logic [sfla_pkg::ID_W-1:0] slot_id;
  logic                      out_valid;
  logic                      out_ready;
  logic [sfla_pkg::ID_W-1:0] granted_id;
  logic [1:0]                status;

  // Predicted allocator state: free stack, its depth, and the next fresh ID.
  logic [sfla_pkg::ID_W-1:0] free_ids [sfla_pkg::SLOT_COUNT];
  int                        free_depth    = 0;
  int                        next_fresh_id = 0;

  // Expected results, oldest first.
  grant_t                    grant_q[$];

  int                        mismatch_count = 0;
  int                        idle_cycles    = 0;
  int                        hold_cycles    = 0;
  // When set, neither side inserts idle cycles.
  bit                        steady         = 1'b0;

  slot_id_free_list_allocator_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .slot_id    (slot_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .granted_id (granted_id),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_valid <= 1'b0;
    mode     <= sfla_pkg::MODE_ALLOC;
    slot_id  <= '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Advance the local free-list model by one request and queue its answer.
  task automatic predict_grant(input logic req_mode,
                               input logic [sfla_pkg::ID_W-1:0] req_id);
    grant_t g;
    g.granted = '0;
    g.status  = sfla_pkg::ST_OK;
    if (req_mode == sfla_pkg::MODE_ALLOC) begin
      if (free_depth > 0) begin
        // Pop the most recently released ID.
        free_depth--;
        g.granted = free_ids[free_depth];
      end else if (next_fresh_id < sfla_pkg::SLOT_COUNT) begin
        // Stack empty: hand out the high-water mark.
        g.granted = next_fresh_id[sfla_pkg::ID_W-1:0];
        next_fresh_id++;
      end else begin
        g.status = sfla_pkg::ST_FULL;
      end
    end else begin
      if (int'(req_id) >= next_fresh_id) begin
        g.status = sfla_pkg::ST_NOT_ISSUED;
      end else if (free_depth >= sfla_pkg::SLOT_COUNT) begin
        // Only repeated releases of the same ID can get here; drop it.
        g.status = sfla_pkg::ST_OVERFLOW;
      end else begin
        free_ids[free_depth] = req_id;
        free_depth++;
      end
    end
    grant_q.insert(grant_q.size(), g);
  endtask

  // Offer one request, hold it until the transfer, then predict its result.
  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_request(input logic req_mode,
                              input logic [sfla_pkg::ID_W-1:0] req_id);
    int gap;
    if (!steady && $urandom_range(99) < 12) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= req_mode;
    slot_id  <= req_id;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_grant(req_mode, req_id);
  endtask

  // Release an ID that is already out, or else any ID.
  task automatic send_random_release(input int issued_pct);
    logic [sfla_pkg::ID_W-1:0] id;
    if (next_fresh_id > 0 && $urandom_range(99) < issued_pct)
      id = sfla_pkg::ID_W'($urandom_range(next_fresh_id - 1));
    else
      id = sfla_pkg::ID_W'($urandom_range(sfla_pkg::SLOT_COUNT - 1));
    send_request(sfla_pkg::MODE_RELEASE, id);
  endtask

  task automatic send_random_request(input int alloc_pct);
    if ($urandom_range(99) < alloc_pct)
      // The ID is ignored on allocate; randomize it anyway.
      send_request(sfla_pkg::MODE_ALLOC,
                   sfla_pkg::ID_W'($urandom_range(sfla_pkg::SLOT_COUNT - 1)));
    else
      send_random_release(75);
  endtask

  // Walk the basic cases: fresh grants, LIFO reuse, releases at and past the
  // high-water mark, ID extremes on both operations.
  task automatic test_directed_basics();
    send_request(sfla_pkg::MODE_ALLOC, '1);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_ALLOC, 10'h2AA);
    send_request(sfla_pkg::MODE_RELEASE, 10'd2);
    send_request(sfla_pkg::MODE_RELEASE, 10'd3);
    send_request(sfla_pkg::MODE_RELEASE, '1);
    send_request(sfla_pkg::MODE_RELEASE, '0);
    send_request(sfla_pkg::MODE_ALLOC, 10'h155);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_RELEASE, 10'd1);
    send_request(sfla_pkg::MODE_RELEASE, 10'd3);
    send_request(sfla_pkg::MODE_RELEASE, 10'd0);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_ALLOC, '0);
    send_request(sfla_pkg::MODE_RELEASE, 10'd4);
    send_request(sfla_pkg::MODE_RELEASE, 10'd5);
  endtask

  // Alternate release-heavy and allocate-heavy phases so the stack both
  // deepens and drains back to fresh grants.
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++)
      send_random_request(((i / 50) % 2 == 0) ? 35 : 65);
  endtask

  // Run back-to-back with no idle cycles on either side.
  task automatic test_steady_burst(input int count);
    steady = 1'b1;
    for (int i = 0; i < count; i++)
      send_random_request(50);
    steady = 1'b0;
  endtask

  // Stall the receiver for a long stretch while requests keep coming.
  task automatic test_back_pressure(input int count);
    hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < count; i++)
      send_random_request(50);
  endtask

  // Allocate until the stack is empty and every ID is out, then keep asking.
  task automatic test_table_full();
    while (free_depth > 0 || next_fresh_id < sfla_pkg::SLOT_COUNT)
      send_request(sfla_pkg::MODE_ALLOC,
                   sfla_pkg::ID_W'($urandom_range(sfla_pkg::SLOT_COUNT - 1)));
    repeat (3) send_request(sfla_pkg::MODE_ALLOC, '1);
    send_request(sfla_pkg::MODE_RELEASE, '1);
    send_request(sfla_pkg::MODE_RELEASE, '0);
    send_request(sfla_pkg::MODE_RELEASE, 10'h200);
    repeat (4) send_request(sfla_pkg::MODE_ALLOC, '0);
  endtask

  // Release one ID until the stack is full, overflow it, then pop a few back.
  task automatic test_stack_overflow();
    logic [sfla_pkg::ID_W-1:0] id;
    id = sfla_pkg::ID_W'($urandom_range(sfla_pkg::SLOT_COUNT - 1));
    while (free_depth < sfla_pkg::SLOT_COUNT)
      send_request(sfla_pkg::MODE_RELEASE, id);
    send_request(sfla_pkg::MODE_RELEASE, id);
    send_request(sfla_pkg::MODE_RELEASE, '1);
    send_request(sfla_pkg::MODE_RELEASE, '0);
    repeat (8)
      send_request(sfla_pkg::MODE_ALLOC,
                   sfla_pkg::ID_W'($urandom_range(sfla_pkg::SLOT_COUNT - 1)));
  endtask

  // Receiver: honor a requested hold-off first, otherwise idle at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 19);
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("result with no request pending", int'(granted_id), 0);
      end else begin
        want = grant_q.pop_front();
        if (granted_id !== want.granted)
          report_mismatch("granted_id", int'(granted_id), int'(want.granted));
        if (status !== want.status)
          report_mismatch("status", int'(status), int'(want.status));
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_random_traffic(150);
    test_steady_burst(80);
    test_back_pressure(40);
    test_random_traffic(60);
    test_table_full();
    test_stack_overflow();

    // Stop offering, drain every pending result, then let the pipe settle.
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
